@@ rtl/bstc_pkg.sv @@
// shared types and constants for the beacon switch time calculator
package bstc_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned TuW   = 16;
  localparam int unsigned CntW  = 8;

  // configuration register indexes
  localparam logic CfgBeaconInterval    = 1'b0;
  localparam logic CfgBssBeaconInterval = 1'b1;

  typedef struct packed {
    logic [DataW-1:0] current_beacon_time;
    logic [DataW-1:0] tsf_low_word;
    logic [CntW-1:0]  beacons_until_switch;
  } in_t;

  typedef struct packed {
    logic [DataW-1:0] switch_at;
    logic             switch_now;
  } out_t;

endpackage

@@ rtl/bstc_div.sv @@
// pipelined restoring divider, one quotient bit per stage, with sideband
module bstc_div #(
  parameter int unsigned W  = 32,
  parameter int unsigned SW = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  logic [W-1:0]  dividend_i,
  input  logic [W-1:0]  divisor_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [W-1:0]  quotient_o,
  output logic [W-1:0]  remainder_o,
  output logic [SW-1:0] side_o
);

  logic          vld_q [W];
  logic [W-1:0]  rem_q [W];
  logic [W-1:0]  dvd_q [W];
  logic [W-1:0]  dvs_q [W];
  logic [SW-1:0] side_q [W];

  logic          vld_s [W];
  logic [W-1:0]  rem_s [W];
  logic [W-1:0]  dvd_s [W];
  logic [W-1:0]  dvs_s [W];
  logic [SW-1:0] side_s [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W:0]   trial;
    logic         take;
    logic [W-1:0] rem_d;
    logic [W-1:0] dvd_d;

    if (k == 0) begin : g_first
      assign vld_s[k]  = valid_i;
      assign rem_s[k]  = '0;
      assign dvd_s[k]  = dividend_i;
      assign dvs_s[k]  = divisor_i;
      assign side_s[k] = side_i;
    end else begin : g_next
      assign vld_s[k]  = vld_q[k-1];
      assign rem_s[k]  = rem_q[k-1];
      assign dvd_s[k]  = dvd_q[k-1];
      assign dvs_s[k]  = dvs_q[k-1];
      assign side_s[k] = side_q[k-1];
    end

    always_comb begin
      trial = {rem_s[k], dvd_s[k][W-1]};
      take  = (trial >= {1'b0, dvs_s[k]});
      rem_d = take ? W'(trial - {1'b0, dvs_s[k]}) : trial[W-1:0];
      dvd_d = {dvd_s[k][W-2:0], take};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_s[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= rem_d;
        dvd_q[k]  <= dvd_d;
        dvs_q[k]  <= dvs_s[k];
        side_q[k] <= side_s[k];
      end
    end
  end

  assign valid_o     = vld_q[W-1];
  assign quotient_o  = dvd_q[W-1];
  assign remainder_o = rem_q[W-1];
  assign side_o      = side_q[W-1];

endmodule

@@ rtl/beacon_switch_time_calc.sv @@
// top level: channel switch time in extended beacon format, fully pipelined
// pipeline: 2*32 divider stages plus 6 more register stages
// throughput: one item per cycle; a stalled output freezes the whole pipeline
// the two 32-stage restoring dividers set the latency
// reset clears valid bits and sets both interval registers to 100 time units
module beacon_switch_time_calc #(
  parameter int unsigned EXT_SPLIT_BITS = 22,
  parameter int unsigned USEC_PER_TU    = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  bstc_pkg::in_t                     in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output bstc_pkg::out_t                    out_data_o,
  input  logic                              cfg_we_i,
  input  logic                              cfg_idx_i,
  input  logic [bstc_pkg::TuW-1:0]          cfg_data_i
);

  localparam int unsigned W  = bstc_pkg::DataW;
  localparam int unsigned CW = bstc_pkg::CntW;
  localparam int unsigned TW = bstc_pkg::TuW;
  localparam logic [W-1:0] UsecK  = W'(USEC_PER_TU);
  localparam logic [W-1:0] LoMask = W'((64'd1 << EXT_SPLIT_BITS) - 64'd1);
  localparam logic [W-1:0] StepK  = W'(64'd1 << EXT_SPLIT_BITS);
  localparam int unsigned S1W = W + CW + 1;
  localparam int unsigned S2W = W + 2;

  logic en;
  logic [TW-1:0] bi_q, bss_q;
  logic [W-1:0]  interval_q;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bi_q  <= TW'(100);
      bss_q <= TW'(100);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == bstc_pkg::CfgBeaconInterval) begin
        bi_q <= cfg_data_i;
      end else begin
        bss_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    interval_q <= W'({{(W-TW){1'b0}}, bi_q} * UsecK);
  end

  // stage 0: difference and reduction enable
  logic          v0_q;
  logic [W-1:0]  now0_q, diff0_q;
  logic [CW-1:0] cnt0_q;
  logic          red0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      now0_q  <= in_data_i.current_beacon_time;
      diff0_q <= in_data_i.current_beacon_time - in_data_i.tsf_low_word;
      cnt0_q  <= in_data_i.beacons_until_switch;
      red0_q  <= (in_data_i.current_beacon_time > in_data_i.tsf_low_word) && (bi_q != '0);
    end
  end

  // passed intervals
  logic           vd1;
  logic [W-1:0]   q1, r1;
  logic [S1W-1:0] side1;

  bstc_div #(.W(W), .SW(S1W)) u_div_passed (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (v0_q),
    .dividend_i  (diff0_q),
    .divisor_i   ({{(W-TW){1'b0}}, bi_q}),
    .side_i      ({now0_q, cnt0_q, red0_q}),
    .valid_o     (vd1),
    .quotient_o  (q1),
    .remainder_o (r1),
    .side_o      (side1)
  );

  // stage 1: reduce count
  logic          v1_q;
  logic [W-1:0]  now1_q;
  logic [CW-1:0] cnt1_q;
  logic [W-1:0]  s1_now;
  logic [CW-1:0] s1_cnt;
  logic          s1_red;

  assign {s1_now, s1_cnt, s1_red} = side1;

  // stage 2: count times bss interval
  logic               v2_q, now2_flag_q;
  logic [W-1:0]       now2_q;
  logic [TW+CW-1:0]   prod2_q;

  // stage 3: microseconds
  logic          v3_q, sw3_q, zf3;
  logic [W-1:0]  now3_q, usec3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (en) begin
      v1_q <= vd1;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      now1_q <= s1_now;
      if (!s1_red) begin
        cnt1_q <= s1_cnt;
      end else if ({{(W-CW){1'b0}}, s1_cnt} > q1) begin
        cnt1_q <= s1_cnt - q1[CW-1:0];
      end else begin
        cnt1_q <= '0;
      end
      now2_q      <= now1_q;
      now2_flag_q <= (cnt1_q <= CW'(1));
      prod2_q     <= (TW+CW)'(bss_q) * (TW+CW)'(cnt1_q);
      now3_q      <= now2_q;
      sw3_q       <= now2_flag_q;
      usec3_q     <= W'({{(W-TW-CW){1'b0}}, prod2_q} * UsecK);
    end
  end

  always_comb begin
    zf3 = (usec3_q == '0) || (interval_q == '0);
  end

  // offset conversion
  logic           vd2;
  logic [W-1:0]   q2, r2;
  logic [S2W-1:0] side2;

  bstc_div #(.W(W), .SW(S2W)) u_div_offset (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (v3_q),
    .dividend_i  (usec3_q),
    .divisor_i   (interval_q),
    .side_i      ({now3_q, sw3_q, zf3}),
    .valid_o     (vd2),
    .quotient_o  (q2),
    .remainder_o (r2),
    .side_o      (side2)
  );

  // stage 4: extended offset
  logic         v4_q, sw4_q;
  logic [W-1:0] now4_q, ext4_q;
  logic [W-1:0] s2_now;
  logic         s2_sw, s2_zf;

  assign {s2_now, s2_sw, s2_zf} = side2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (en) begin
      v4_q <= vd2;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      now4_q <= s2_now;
      sw4_q  <= s2_sw;
      ext4_q <= s2_zf ? '0 : ((q2 << EXT_SPLIT_BITS) | (r2 & LoMask));
    end
  end

  // stage 5: add with carry into the count part, output register
  logic         out_v_q;
  bstc_pkg::out_t out_q;
  logic [W-1:0] b_lo, a_lo, hi_sum, lo_add;

  always_comb begin
    b_lo   = now4_q & LoMask;
    a_lo   = ext4_q & LoMask;
    hi_sum = (now4_q & ~LoMask) + (ext4_q & ~LoMask);
    if (b_lo > a_lo) begin
      lo_add = b_lo - a_lo;
    end else if (b_lo < a_lo) begin
      lo_add = interval_q + b_lo - a_lo + StepK;
    end else begin
      lo_add = StepK;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en) begin
      out_v_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.switch_now <= sw4_q;
      out_q.switch_at  <= sw4_q ? now4_q : hi_sum + lo_add;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output item changed while stalled");

  a_ready_rule: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o == (!out_valid_o || out_ready_i))
    else $error("input ready does not follow output stall");

  a_cfg_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_idx_i == bstc_pkg::CfgBeaconInterval |=> bi_q == $past(cfg_data_i))
    else $error("beacon interval write lost");
`endif

endmodule

@@ test/beacon_switch_time_calc_tb.sv @@
// testbench for the beacon switch time calculator: random and directed items checked in order
module beacon_switch_time_calc_tb;

  localparam int unsigned SplitBits = 22;
  localparam int unsigned UsecPerTu = 1024;
  localparam int unsigned Latency   = 70;

  class switch_board;
    bstc_pkg::out_t pending_q[$];
    int   n_errors;
    int   n_checked;
    int   n_now;
    logic [15:0] bi;
    logic [15:0] bss_bi;

    function new();
      n_errors  = 0;
      n_checked = 0;
      n_now     = 0;
      bi        = 16'd100;
      bss_bi    = 16'd100;
    endfunction

    function bstc_pkg::out_t calc_expected(bstc_pkg::in_t req);
      bstc_pkg::out_t res;
      logic [31:0] now;
      logic [31:0] tsf;
      logic [31:0] cnt;
      logic [31:0] period;
      logic [31:0] passed;
      logic [31:0] usec;
      logic [31:0] ext;
      logic [31:0] lm;
      logic [31:0] b_lo;
      logic [31:0] a_lo;
      logic [31:0] sum;
      now    = req.current_beacon_time;
      tsf    = req.tsf_low_word;
      cnt    = {24'd0, req.beacons_until_switch};
      period = 32'(bi) * UsecPerTu;
      lm     = (32'd1 << SplitBits) - 1;
      if (now > tsf && bi != 0) begin
        passed = (now - tsf) / 32'(bi);
        cnt = (cnt > passed) ? cnt - passed : 32'd0;
      end
      if (cnt <= 1) begin
        res.switch_at  = now;
        res.switch_now = 1'b1;
      end else begin
        usec = 32'(bss_bi) * cnt * UsecPerTu;
        if (period == 0 || usec == 0) begin
          ext = 32'd0;
        end else begin
          ext = (((usec / period) & ((32'd1 << (32 - SplitBits)) - 1)) << SplitBits)
              + ((usec % period) & lm);
        end
        b_lo = now & lm;
        a_lo = ext & lm;
        sum  = (now & ~lm) + (ext & ~lm);
        if (b_lo > a_lo) begin
          sum += b_lo - a_lo;
        end else if (b_lo < a_lo) begin
          sum += period + b_lo - a_lo;
          sum += 32'd1 << SplitBits;
        end else begin
          sum += 32'd1 << SplitBits;
        end
        res.switch_at  = sum;
        res.switch_now = 1'b0;
      end
      return res;
    endfunction

    function void note_request(bstc_pkg::in_t req);
      pending_q.push_back(calc_expected(req));
    endfunction

    function void check_result(bstc_pkg::out_t got);
      bstc_pkg::out_t exp_res;
      if (pending_q.size() == 0) begin
        $error("unexpected item: switch_at %h switch_now %b", got.switch_at, got.switch_now);
        n_errors++;
        return;
      end
      exp_res = pending_q.pop_front();
      n_checked++;
      if (got.switch_now) n_now++;
      if (got.switch_at !== exp_res.switch_at) begin
        $error("switch_at: expected %h actual %h", exp_res.switch_at, got.switch_at);
        n_errors++;
      end
      if (got.switch_now !== exp_res.switch_now) begin
        $error("switch_now: expected %b actual %b", exp_res.switch_now, got.switch_now);
        n_errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  bstc_pkg::in_t  in_data;
  logic out_valid;
  logic out_ready;
  bstc_pkg::out_t out_data;
  logic cfg_we;
  logic cfg_idx;
  logic [bstc_pkg::TuW-1:0] cfg_data;

  switch_board board;
  bit   calm;
  bit   hold_off;
  bit   stim_done;

  beacon_switch_time_calc dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("TEST FAILED");
    $finish;
  end

  task automatic write_cfg(logic idx, logic [15:0] val);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bstc_pkg::CfgBeaconInterval) board.bi = val;
    else board.bss_bi = val;
  endtask

  task automatic send_item(bstc_pkg::in_t req);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    board.note_request(req);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (Latency + 10) @(posedge clk);
  endtask

  function automatic bstc_pkg::in_t rand_item(bit near);
    bstc_pkg::in_t r;
    r.current_beacon_time = $urandom();
    r.tsf_low_word = near ? r.current_beacon_time - $urandom_range(0, 2000) : $urandom();
    r.beacons_until_switch = $urandom_range(0, 255);
    if ($urandom_range(0, 5) == 0) r.beacons_until_switch = $urandom_range(0, 3);
    return r;
  endfunction

  // receiver
  initial begin
    int gap;
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_off) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        gap = $urandom_range(1, 5);
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      if (out_valid && out_ready) board.check_result(out_data);
    end
  end

  initial begin
    bstc_pkg::in_t req;
    logic [15:0] bi_set[6];
    logic [15:0] bss_set[6];
    board     = new();
    calm      = 1'b0;
    hold_off  = 1'b0;
    stim_done = 1'b0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = bstc_pkg::CfgBeaconInterval;
    cfg_data  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset intervals
    send_item('{32'hFFFF_FFFF, 32'h0000_0000, 8'd255});
    send_item('{32'h0000_0000, 32'hFFFF_FFFF, 8'd255});
    send_item('{32'h0000_0000, 32'h0000_0000, 8'd0});
    send_item('{32'h1234_5678, 32'h1234_5678, 8'd1});
    send_item('{32'h1234_5678, 32'h1234_5678, 8'd2});
    send_item('{32'h1234_5678, 32'h1234_0000, 8'd200});
    send_item('{32'h003F_FFFF, 32'h0040_0000, 8'd10});
    send_item('{32'hFFC0_0000, 32'hFFC0_0000, 8'd255});
    send_item('{32'h0001_9000, 32'hFFFF_FFFF, 8'd3});
    send_item('{32'h0000_0005, 32'h0000_0000, 8'd5});
    drain();
    // zero context interval and zero bss interval
    write_cfg(bstc_pkg::CfgBeaconInterval, 16'd0);
    write_cfg(bstc_pkg::CfgBssBeaconInterval, 16'd0);
    send_item('{32'h5555_5555, 32'h0000_0000, 8'd77});
    send_item('{32'hAAAA_AAAA, 32'h0000_0001, 8'd1});
    drain();
    write_cfg(bstc_pkg::CfgBssBeaconInterval, 16'hFFFF);
    send_item('{32'h0A00_0000, 32'h0000_0000, 8'd255});
    drain();
    write_cfg(bstc_pkg::CfgBeaconInterval, 16'hFFFF);
    send_item('{32'hFFFF_FFFF, 32'h0000_0000, 8'd255});
    send_item('{32'h0030_0000, 32'h0000_0000, 8'd255});
    send_item('{32'h0000_0000, 32'h0000_0000, 8'd128});
    drain();
    write_cfg(bstc_pkg::CfgBeaconInterval, 16'd1);
    write_cfg(bstc_pkg::CfgBssBeaconInterval, 16'd1);
    send_item('{32'h0000_0010, 32'h0000_0008, 8'd12});
    send_item('{32'h0000_0000, 32'h0000_0000, 8'd255});
    drain();

    bi_set  = '{16'd100, 16'd0, 16'hFFFF, 16'd1, 16'd64, 16'd100};
    bss_set = '{16'd100, 16'hFFFF, 16'd0, 16'd3000, 16'd1, 16'd100};
    for (int ph = 0; ph < 6; ph++) begin
      write_cfg(bstc_pkg::CfgBeaconInterval,
                $urandom_range(0, 4) == 0 ? 16'($urandom()) : bi_set[ph]);
      write_cfg(bstc_pkg::CfgBssBeaconInterval, bss_set[ph]);
      if (ph == 5) calm = 1'b1;
      for (int i = 0; i < 90; i++) begin
        if (ph == 2 && i == 20) hold_off = 1'b1;
        req = rand_item($urandom_range(0, 2) != 0);
        send_item(req);
      end
      drain();
    end
    stim_done = 1'b1;

    $display("covered %0d results (%0d immediate) over several interval settings",
             board.n_checked, board.n_now);
    if (board.n_errors == 0 && board.pending_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/bstc_pkg.sv
rtl/bstc_div.sv
rtl/beacon_switch_time_calc.sv
test/beacon_switch_time_calc_tb.sv
